// ----- hdl/kmw_pkg.sv -----
// Shared constants, sequencer states and control bundles for the spanning tree weight block.
package kmw_pkg;

  localparam int MAX_NODES = 256;
  localparam int MAX_EDGES = 1024;

  localparam int NODE_W  = 8;
  localparam int WT_W    = 16;
  localparam int EIDX_W  = $clog2(MAX_EDGES);
  localparam int FILL_W  = EIDX_W + 1;
  localparam int SIZE_W  = $clog2(MAX_NODES) + 1;
  localparam int CNT_W   = 9;
  localparam int EDGE_W  = 2 * NODE_W + WT_W;
  localparam int ACC_W   = WT_W + FILL_W;
  localparam int TOT_W   = 24;
  localparam int TAKEN_W = 8;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-1:0] CFG_NODE_COUNT_ADDR = 3'd0;
  localparam logic [CNT_W-1:0]  NODE_COUNT_RESET    = 9'd256;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_FA_RD,
    ST_FA_EV,
    ST_FB_RD,
    ST_FB_EV,
    ST_SZ_A,
    ST_SZ_B,
    ST_SZ_M,
    ST_FINISH
  } kmw_state_t;

  typedef struct packed {
    logic load;       // store the accepted edge
    logic start;      // arm a new computation
    logic clr_step;   // write one union-find entry back to its reset value
    logic edge_eval;  // take the fetched edge, update next weight, advance
    logic next_pass;  // move to the next weight class
    logic find_step;  // follow one parent link
    logic root_a;     // keep the first root, begin on the second endpoint
    logic root_b;     // keep the second root
    logic size_sel_b; // read the size of the second root
    logic size_cap_a; // hold the size of the first root
    logic merge;      // join the two sets and count the edge
    logic finish;     // publish the result and clear for the next graph
  } kmw_cmd_t;

  typedef struct packed {
    logic at_end;
    logic edge_hit;
    logic have_nxt;
    logic root_hit;
    logic same_root;
    logic clr_last;
    logic out_full;
  } kmw_stat_t;

endpackage

// ----- hdl/kmw_ctrl.sv -----
// Sequencer for loading, weight-class scans, root finds and set merges.
module kmw_ctrl
  import kmw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last_edge,
  output logic      in_stall,
  input  kmw_stat_t stat,
  output kmw_cmd_t  cmd
);

  kmw_state_t state_r, state_nxt;

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Pick the next state and drive the datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last_edge) begin
            cmd.start = 1'b1;
            state_nxt = ST_CLR;
          end
        end
      end
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        if (stat.at_end) begin
          if (stat.have_nxt) begin
            cmd.next_pass = 1'b1;
          end else begin
            state_nxt = ST_FINISH;
          end
        end else begin
          state_nxt = ST_SCAN_EV;
        end
      end
      ST_SCAN_EV: begin
        cmd.edge_eval = 1'b1;
        state_nxt = stat.edge_hit ? ST_FA_RD : ST_SCAN_RD;
      end
      ST_FA_RD: state_nxt = ST_FA_EV;
      ST_FA_EV: begin
        if (stat.root_hit) begin
          cmd.root_a = 1'b1;
          state_nxt  = ST_FB_RD;
        end else begin
          cmd.find_step = 1'b1;
          state_nxt     = ST_FA_RD;
        end
      end
      ST_FB_RD: state_nxt = ST_FB_EV;
      ST_FB_EV: begin
        if (stat.root_hit) begin
          cmd.root_b = 1'b1;
          state_nxt  = stat.same_root ? ST_SCAN_RD : ST_SZ_A;
        end else begin
          cmd.find_step = 1'b1;
          state_nxt     = ST_FB_RD;
        end
      end
      ST_SZ_A: state_nxt = ST_SZ_B;
      ST_SZ_B: begin
        cmd.size_sel_b = 1'b1;
        cmd.size_cap_a = 1'b1;
        state_nxt      = ST_SZ_M;
      end
      ST_SZ_M: begin
        cmd.merge = 1'b1;
        state_nxt = ST_SCAN_RD;
      end
      ST_FINISH: begin
        if (!stat.out_full) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- hdl/kmw_dp.sv -----
// Edge store, union-find tables, scan registers, sums and the result register.
module kmw_dp
  import kmw_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  kmw_cmd_t                  cmd,
  output kmw_stat_t                 stat,
  input  logic [CNT_W-1:0]          node_count,
  input  logic [NODE_W-1:0]         in_node_a,
  input  logic [NODE_W-1:0]         in_node_b,
  input  logic signed [WT_W-1:0]    in_edge_weight,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [TOT_W-1:0]   out_total_weight,
  output logic [TAKEN_W-1:0]        out_edges_taken,
  output logic                      out_dropped_flag
);

  localparam logic signed [ACC_W-1:0] TOT_MAX = ACC_W'((1 <<< (TOT_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] TOT_MIN = -ACC_W'(1 <<< (TOT_W - 1));

  // Storage
  logic [EDGE_W-1:0] edge_mem [MAX_EDGES];
  logic [NODE_W-1:0] parent_mem [MAX_NODES];
  logic [SIZE_W-1:0] size_mem [MAX_NODES];

  logic [FILL_W-1:0]        fill_r;
  logic                     drop_r;
  logic [NODE_W-1:0]        clr_idx_r;
  logic [FILL_W-1:0]        scan_idx_r;
  logic [EDGE_W-1:0]        edata_r;
  logic [EDGE_W-1:0]        edge_r;
  logic [NODE_W-1:0]        pdata_r;
  logic [SIZE_W-1:0]        sdata_r;
  logic [SIZE_W-1:0]        size_a_r;
  logic [NODE_W-1:0]        x_r;
  logic [NODE_W-1:0]        ra_r;
  logic [NODE_W-1:0]        rb_r;
  logic signed [WT_W-1:0]   cur_r;
  logic                     have_cur_r;
  logic signed [WT_W-1:0]   nxt_r;
  logic                     have_nxt_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [TAKEN_W-1:0]       taken_r;
  logic                     out_valid_r;
  logic signed [TOT_W-1:0]  out_total_r;
  logic [TAKEN_W-1:0]       out_taken_r;
  logic                     out_drop_r;

  logic [CNT_W-1:0]        limit;
  logic                    edge_ok;
  logic signed [WT_W-1:0]  ew;
  logic                    above_cur;
  logic [NODE_W-1:0]       size_addr;
  logic                    a_small;
  logic [SIZE_W-1:0]       size_sum;
  logic signed [TOT_W-1:0] tot_sat;

  // Accept check: both endpoints in range and room left in the store
  assign limit   = (node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count;
  assign edge_ok = ({1'b0, in_node_a} < limit) && ({1'b0, in_node_b} < limit) &&
                   (fill_r != FILL_W'(MAX_EDGES));

  assign ew        = edata_r[EDGE_W-1 -: WT_W];
  assign above_cur = !have_cur_r || (ew > cur_r);
  assign size_addr = cmd.size_sel_b ? rb_r : ra_r;
  assign a_small   = size_a_r < sdata_r;
  assign size_sum  = size_a_r + sdata_r;

  // Saturate the running total to the result width
  always_comb begin
    if (acc_r > TOT_MAX) begin
      tot_sat = TOT_MAX[TOT_W-1:0];
    end else if (acc_r < TOT_MIN) begin
      tot_sat = TOT_MIN[TOT_W-1:0];
    end else begin
      tot_sat = acc_r[TOT_W-1:0];
    end
  end

  // Edge store: write on load, registered read at the scan index
  always_ff @(posedge clk) begin
    if (cmd.load && edge_ok) begin
      edge_mem[fill_r[EIDX_W-1:0]] <= {in_edge_weight, in_node_b, in_node_a};
    end
    edata_r <= edge_mem[scan_idx_r[EIDX_W-1:0]];
  end

  // Parent table: reset sweep or link on merge, registered read at the find pointer
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      parent_mem[clr_idx_r] <= clr_idx_r;
    end else if (cmd.merge) begin
      if (a_small) begin
        parent_mem[ra_r] <= rb_r;
      end else begin
        parent_mem[rb_r] <= ra_r;
      end
    end
    pdata_r <= parent_mem[x_r];
  end

  // Set sizes: reset sweep or grow the surviving root
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      size_mem[clr_idx_r] <= SIZE_W'(1);
    end else if (cmd.merge) begin
      size_mem[a_small ? rb_r : ra_r] <= size_sum;
    end
    sdata_r <= size_mem[size_addr];
  end

  // Control registers: fill count, drop flag, scan progress, result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      drop_r      <= 1'b0;
      clr_idx_r   <= '0;
      scan_idx_r  <= '0;
      have_cur_r  <= 1'b0;
      have_nxt_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (edge_ok) begin
          fill_r <= fill_r + FILL_W'(1);
        end else begin
          drop_r <= 1'b1;
        end
      end
      if (cmd.start) begin
        clr_idx_r  <= '0;
        scan_idx_r <= '0;
        have_cur_r <= 1'b0;
        have_nxt_r <= 1'b0;
      end
      if (cmd.clr_step) clr_idx_r <= clr_idx_r + NODE_W'(1);
      if (cmd.edge_eval) begin
        scan_idx_r <= scan_idx_r + FILL_W'(1);
        if (above_cur && (!have_nxt_r || ew < nxt_r)) have_nxt_r <= 1'b1;
      end
      if (cmd.next_pass) begin
        scan_idx_r <= '0;
        have_cur_r <= 1'b1;
        have_nxt_r <= 1'b0;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        fill_r      <= '0;
        drop_r      <= 1'b0;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: weights, roots, sums and the result
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_r   <= '0;
      taken_r <= '0;
    end
    if (cmd.edge_eval) begin
      edge_r <= edata_r;
      x_r    <= edata_r[NODE_W-1:0];
      if (above_cur && (!have_nxt_r || ew < nxt_r)) nxt_r <= ew;
    end
    if (cmd.next_pass) cur_r <= nxt_r;
    if (cmd.find_step) x_r <= pdata_r;
    if (cmd.root_a) begin
      ra_r <= x_r;
      x_r  <= edge_r[2*NODE_W-1:NODE_W];
    end
    if (cmd.root_b) rb_r <= x_r;
    if (cmd.size_cap_a) size_a_r <= sdata_r;
    if (cmd.merge) begin
      acc_r <= acc_r + ACC_W'($signed(edge_r[EDGE_W-1 -: WT_W]));
      if (taken_r != '1) taken_r <= taken_r + TAKEN_W'(1);
    end
    if (cmd.finish) begin
      out_total_r <= tot_sat;
      out_taken_r <= taken_r;
      out_drop_r  <= drop_r;
    end
  end

  // Status back to the sequencer
  assign stat.at_end    = (scan_idx_r == fill_r);
  assign stat.edge_hit  = have_cur_r && (ew == cur_r);
  assign stat.have_nxt  = have_nxt_r;
  assign stat.root_hit  = (pdata_r == x_r);
  assign stat.same_root = (x_r == ra_r);
  assign stat.clr_last  = (clr_idx_r == NODE_W'(MAX_NODES - 1));
  assign stat.out_full  = out_valid_r && out_stall;

  assign out_valid        = out_valid_r;
  assign out_total_weight = out_total_r;
  assign out_edges_taken  = out_taken_r;
  assign out_dropped_flag = out_drop_r;

endmodule

// ----- hdl/kruskal_mst_weight.sv -----
// Top level: configuration register port and the sequencer/datapath pair.
// Edges load one per cycle into a 1024-entry store; an edge with an endpoint at or above
// node_count (limited to 256), or arriving with the store full, is dropped and flagged.
// The edge marked last starts the computation, during which in_stall stays high: a pass
// over all 256 table entries resets the union-find tables, then the edge store is scanned
// once to find the lowest weight and then once per distinct weight through its single read
// port, and every edge of the current weight runs two root searches over the parent table
// plus, when the two roots differ, a merge by set size. One result follows each last edge:
// the saturated 24-bit total, the taken-edge count and the drop flag; it is held in an
// output register so the next graph may load while it waits.
module kruskal_mst_weight
  import kmw_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [NODE_W-1:0]        in_node_a,
  input  logic [NODE_W-1:0]        in_node_b,
  input  logic signed [WT_W-1:0]   in_edge_weight,
  input  logic                     in_last_edge,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [TOT_W-1:0]  out_total_weight,
  output logic [TAKEN_W-1:0]       out_edges_taken,
  output logic                     out_dropped_flag,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_AW-1:0]        cfg_paddr,
  input  logic [CFG_DW-1:0]        cfg_pwdata,
  output logic [CFG_DW-1:0]        cfg_prdata,
  output logic                     cfg_pready
);

  logic [CNT_W-1:0] node_count_r;
  kmw_cmd_t         cmd;
  kmw_stat_t        stat;

  assign cfg_pready = 1'b1;

  // Write the node count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 (cfg_paddr == CFG_NODE_COUNT_ADDR)) begin
      node_count_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  // Read back
  assign cfg_prdata = (cfg_paddr == CFG_NODE_COUNT_ADDR) ?
                      CFG_DW'(node_count_r) : '0;

  kmw_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_edge (in_last_edge),
    .in_stall     (in_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  kmw_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .node_count       (node_count_r),
    .in_node_a        (in_node_a),
    .in_node_b        (in_node_b),
    .in_edge_weight   (in_edge_weight),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_total_weight (out_total_weight),
    .out_edges_taken  (out_edges_taken),
    .out_dropped_flag (out_dropped_flag)
  );

endmodule

// ----- test/kruskal_mst_weight_tb.sv -----
// Self-checking testbench for the spanning tree weight block: directed table, store overfill, random graphs.
module kruskal_mst_weight_tb
  import kmw_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int HOLD_CYCLES    = 3000;
  localparam int RANDOM_ITEMS   = 195;
  localparam logic [CFG_AW-1:0] CFG_UNUSED_ADDR = 3'd4;

  typedef struct packed {
    logic signed [TOT_W-1:0] total;
    logic [TAKEN_W-1:0]      taken;
    logic                    dropped;
  } mst_result_t;

  typedef struct {
    int                      cfg_addr;   // -1: no register write before this row
    int                      cfg_val;
    logic [NODE_W-1:0]       a;
    logic [NODE_W-1:0]       b;
    logic signed [WT_W-1:0]  w;
    logic                    last;
    bit                      typed;
    int                      exp_total;
    int                      exp_taken;
    bit                      exp_drop;
  } edge_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [NODE_W-1:0] in_node_a = '0;
  logic [NODE_W-1:0] in_node_b = '0;
  logic signed [WT_W-1:0] in_edge_weight = '0;
  logic in_last_edge = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [TOT_W-1:0] out_total_weight;
  logic [TAKEN_W-1:0] out_edges_taken;
  logic out_dropped_flag;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  kruskal_mst_weight i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: stored edges, sticky drop, node count register
  logic [NODE_W-1:0]      edge_a [MAX_EDGES];
  logic [NODE_W-1:0]      edge_b [MAX_EDGES];
  logic signed [WT_W-1:0] edge_w [MAX_EDGES];
  int          edge_cnt;
  bit          drop_pending;
  int          node_count_q;
  mst_result_t pending_results[$];

  int in_pct, out_pct;
  int hold_req, hold_ack, hold_left;
  int mismatches, items_sent, results_seen, graphs_sent, idle_cycles;
  bit accepted_in;

  // Spanning forest weight of the stored edges; clear the graph afterwards
  function automatic mst_result_t forest_weight();
    int order[MAX_EDGES];
    int par[MAX_NODES];
    int sz[MAX_NODES];
    int i, j, k, ra, rb;
    longint sum;
    int cnt;
    mst_result_t r;
    sum = 0;
    cnt = 0;
    for (i = 0; i < MAX_NODES; i++) begin
      par[i] = i;
      sz[i] = 1;
    end
    for (i = 0; i < edge_cnt; i++) begin
      k = i;
      j = i;
      while (j > 0 && edge_w[order[j-1]] > edge_w[k]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = k;
    end
    for (i = 0; i < edge_cnt; i++) begin
      ra = edge_a[order[i]];
      rb = edge_b[order[i]];
      while (par[ra] != ra) ra = par[ra];
      while (par[rb] != rb) rb = par[rb];
      if (ra != rb) begin
        if (sz[ra] < sz[rb]) begin
          par[ra] = rb;
          sz[rb] += sz[ra];
        end else begin
          par[rb] = ra;
          sz[ra] += sz[rb];
        end
        sum += edge_w[order[i]];
        cnt++;
      end
    end
    if (sum > 8388607) sum = 8388607;
    if (sum < -8388608) sum = -8388608;
    if (cnt > 255) cnt = 255;
    r.total = sum[TOT_W-1:0];
    r.taken = cnt[TAKEN_W-1:0];
    r.dropped = drop_pending;
    edge_cnt = 0;
    drop_pending = 0;
    return r;
  endfunction

  // Store or drop one accepted edge; report the forest on the last one
  function automatic bit load_edge(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b,
                                   input logic signed [WT_W-1:0] w, input logic last,
                                   output mst_result_t r);
    int lim;
    lim = node_count_q < MAX_NODES ? node_count_q : MAX_NODES;
    if (a >= lim || b >= lim || edge_cnt >= MAX_EDGES) begin
      drop_pending = 1;
    end else begin
      edge_a[edge_cnt] = a;
      edge_b[edge_cnt] = b;
      edge_w[edge_cnt] = w;
      edge_cnt++;
    end
    if (last) r = forest_weight();
    return last;
  endfunction

  // Offer one edge and hold it until accepted; the caller drops valid when done
  task automatic send_edge(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b,
                           input logic signed [WT_W-1:0] w, input logic last,
                           input bit typed = 0, input int et = 0, input int en = 0,
                           input bit ed = 0);
    mst_result_t r;
    if ($urandom_range(99) < in_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_pct);
    end
    in_valid <= 1'b1;
    in_node_a <= a;
    in_node_b <= b;
    in_edge_weight <= w;
    in_last_edge <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (load_edge(a, b, w, last, r)) begin
      if (typed) begin
        r.total = TOT_W'(et);
        r.taken = TAKEN_W'(en);
        r.dropped = ed;
      end
      pending_results.insert(pending_results.size(), r);
      graphs_sent++;
    end
  endtask

  // Hold the sender until every expected result has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write one register, then read back the node count register
  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input int val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (addr == CFG_NODE_COUNT_ADDR) node_count_q = val & 'h1FF;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= CFG_NODE_COUNT_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata[CNT_W-1:0] !== node_count_q[CNT_W-1:0]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("node_count readback: expected %0d, got %0d", node_count_q, cfg_prdata);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // One random graph: mostly valid nodes, with ties, bad nodes and self loops mixed in
  task automatic send_graph();
    int n, hi, base, span, wmode, i;
    logic [NODE_W-1:0] a, b;
    logic signed [WT_W-1:0] w;
    n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    hi = (node_count_q < MAX_NODES ? node_count_q : MAX_NODES) - 1;
    span = $urandom_range(1) ? hi : (hi < 6 ? hi : 6);
    base = $urandom_range(0, hi - span);
    wmode = $urandom_range(2);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        a = NODE_W'($urandom_range(255));
        b = NODE_W'($urandom_range(255));
      end else begin
        a = NODE_W'(base + $urandom_range(span));
        b = NODE_W'(base + $urandom_range(span));
      end
      case (wmode)
        0: w = WT_W'($urandom);
        1: w = WT_W'($signed($urandom_range(6)) - 3);
        default: w = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      endcase
      send_edge(a, b, w, i == n - 1);
    end
  endtask

  // Check results, drive the result stall, watch for a hang
  always @(posedge clk) begin
    mst_result_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: total %0d", out_total_weight);
        end else begin
          exp_r = pending_results.pop_front();
          if (out_total_weight !== exp_r.total || out_edges_taken !== exp_r.taken ||
              out_dropped_flag !== exp_r.dropped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                       exp_r.total, exp_r.taken, exp_r.dropped,
                       out_total_weight, out_edges_taken, out_dropped_flag);
          end
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("kruskal_mst_weight test failed");
        $finish;
      end
    end
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_pct);
    end
  end

  edge_row_t rows[16];
  int phase_in[4]  = '{0, 83, 0, 36};
  int phase_out[4] = '{0, 0, 83, 36};
  int phase_nc[4]  = '{256, 20, 2, 200};

  initial begin
    int i, ph, start;
    edge_cnt = 0;
    drop_pending = 0;
    node_count_q = NODE_COUNT_RESET;
    in_pct = 0;
    out_pct = 0;
    hold_req = 0;
    hold_ack = 0;
    hold_left = 0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    graphs_sent = 0;
    idle_cycles = 0;
    // cfg_addr, cfg_val, a, b, w, last, typed, total, taken, drop
    rows[0]  = '{-1, 0, 8'd0, 8'd1, 16'sh7fff, 1'b1, 1, 32767, 1, 0};
    rows[1]  = '{-1, 0, 8'd255, 8'd0, 16'sh8000, 1'b1, 1, -32768, 1, 0};
    rows[2]  = '{-1, 0, 8'd5, 8'd5, 16'sd100, 1'b1, 1, 0, 0, 0};           // self loop
    rows[3]  = '{-1, 0, 8'd0, 8'd1, 16'sd3, 1'b0, 0, 0, 0, 0};
    rows[4]  = '{-1, 0, 8'd1, 8'd2, 16'sd2, 1'b0, 0, 0, 0, 0};
    rows[5]  = '{-1, 0, 8'd0, 8'd2, 16'sd1, 1'b1, 1, 3, 2, 0};             // triangle
    rows[6]  = '{0, 10, 8'd10, 8'd3, 16'sd7, 1'b0, 0, 0, 0, 0};            // bad node
    rows[7]  = '{-1, 0, 8'd3, 8'd4, 16'sd9, 1'b1, 1, 9, 1, 1};
    rows[8]  = '{-1, 0, 8'd2, 8'd200, 16'sd5, 1'b1, 1, 0, 0, 1};           // last dropped
    rows[9]  = '{0, 0, 8'd0, 8'd0, 16'sd1, 1'b1, 1, 0, 0, 1};              // zero nodes
    rows[10] = '{0, 1, 8'd0, 8'd0, -16'sd5, 1'b1, 1, 0, 0, 0};
    rows[11] = '{CFG_UNUSED_ADDR, 3, 8'd0, 8'd0, 16'sd0, 1'b1, 1, 0, 0, 0};
    rows[12] = '{0, 256, 8'd7, 8'd8, -16'sd1, 1'b0, 0, 0, 0, 0};
    rows[13] = '{0, 9, 8'd0, 8'd1, -16'sd2, 1'b1, 0, 0, 0, 0};             // change mid-graph
    rows[14] = '{0, 256, 8'haa, 8'h55, 16'sh5555, 1'b0, 0, 0, 0, 0};
    rows[15] = '{-1, 0, 8'h55, 8'haa, 16'shaaaa, 1'b1, 0, 0, 0, 0};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_write(CFG_UNUSED_ADDR, 0);

    // Directed table
    foreach (rows[i]) begin
      if (rows[i].cfg_addr >= 0) begin
        drain();
        cfg_write(rows[i].cfg_addr, rows[i].cfg_val);
      end
      send_edge(rows[i].a, rows[i].b, rows[i].w, rows[i].last, rows[i].typed,
                rows[i].exp_total, rows[i].exp_taken, rows[i].exp_drop);
    end

    // Overfill the store: 1024 stored edges, the rest dropped
    drain();
    cfg_write(CFG_NODE_COUNT_ADDR, 4);
    for (i = 0; i <= MAX_EDGES; i++)
      send_edge(NODE_W'($urandom_range(3)), NODE_W'($urandom_range(3)),
                WT_W'($urandom_range(1)), i == MAX_EDGES);

    // Random graphs under each idling mix
    for (ph = 0; ph < 4; ph++) begin
      drain();
      cfg_write(CFG_NODE_COUNT_ADDR, phase_nc[ph]);
      in_pct = phase_in[ph];
      out_pct = phase_out[ph];
      if (ph == 0) hold_req++;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) send_graph();
    end

    drain();
    repeat (300) @(posedge clk);
    $display("sent %0d edges in %0d graphs, checked %0d results over four idling mixes",
             items_sent, graphs_sent, results_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("kruskal_mst_weight test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("kruskal_mst_weight test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/kmw_pkg.sv
hdl/kmw_ctrl.sv
hdl/kmw_dp.sv
hdl/kruskal_mst_weight.sv
test/kruskal_mst_weight_tb.sv
